// ===== rtl/tcf_pkg.sv =====
// Package with shared types, constants and the CORDIC angle table for the tilt filter.
`timescale 1ns / 1ps
package tcf_pkg;

  localparam int CordicStepsDefault = 16;
  localparam int CordicStepsMax     = 24;
  localparam int AngW               = 20;
  localparam int CfgIdxW            = 2;
  localparam int CfgDataW           = 17;
  localparam int CordW              = 27;
  localparam int ZW                 = 26;

  localparam logic [CfgIdxW-1:0] CFG_BLEND_WEIGHT  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SAMPLE_PERIOD = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_INITIAL_PITCH = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_INITIAL_ROLL  = 2'd3;

  localparam logic signed [ZW-1:0] Deg180 = 26'sd11796480;

  typedef struct packed {
    logic signed [15:0] pitch_rate;
    logic signed [15:0] roll_rate;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } in_req_t;

  typedef struct packed {
    logic signed [AngW-1:0] pitch_estimate;
    logic signed [AngW-1:0] roll_estimate;
  } out_req_t;

  function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] i);
    case (i)
      5'd0:  atan_entry = 26'sd2949120;
      5'd1:  atan_entry = 26'sd1740967;
      5'd2:  atan_entry = 26'sd919879;
      5'd3:  atan_entry = 26'sd466945;
      5'd4:  atan_entry = 26'sd234379;
      5'd5:  atan_entry = 26'sd117304;
      5'd6:  atan_entry = 26'sd58666;
      5'd7:  atan_entry = 26'sd29335;
      5'd8:  atan_entry = 26'sd14668;
      5'd9:  atan_entry = 26'sd7334;
      5'd10: atan_entry = 26'sd3667;
      5'd11: atan_entry = 26'sd1833;
      5'd12: atan_entry = 26'sd917;
      5'd13: atan_entry = 26'sd458;
      5'd14: atan_entry = 26'sd229;
      5'd15: atan_entry = 26'sd115;
      5'd16: atan_entry = 26'sd57;
      5'd17: atan_entry = 26'sd29;
      5'd18: atan_entry = 26'sd14;
      5'd19: atan_entry = 26'sd7;
      5'd20: atan_entry = 26'sd4;
      5'd21: atan_entry = 26'sd2;
      5'd22: atan_entry = 26'sd1;
      default: atan_entry = 26'sd0;
    endcase
  endfunction

  function automatic logic signed [AngW-1:0] sat20(input logic signed [39:0] v);
    if (v > 40'sd524287) sat20 = 20'sd524287;
    else if (v < -40'sd524288) sat20 = -20'sd524288;
    else sat20 = v[AngW-1:0];
  endfunction

endpackage

// ===== rtl/tcf_queue.sv =====
// Two-entry request queue between the accepting front and the filter engine.
`timescale 1ns / 1ps
module tcf_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_stall,
  input  tcf_pkg::in_req_t wr_data,
  output logic             rd_valid,
  input  logic             rd_take,
  output tcf_pkg::in_req_t rd_data
);
  import tcf_pkg::*;

  in_req_t    mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr_en;

  assign wr_stall = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr_en    = wr_valid && !wr_stall;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_take) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_take};
    end
  end

`ifndef NO_ASSERTIONS
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd_take |-> rd_valid) else $error("queue read while empty");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !rd_take) |=> wr_stall) else $error("full queue accepted");
`endif
endmodule

// ===== rtl/tcf_engine.sv =====
// Filter engine: gyro integration, two shared-unit CORDIC atan2 runs and blending.
`timescale 1ns / 1ps
module tcf_engine #(
  parameter int CORDIC_STEPS = tcf_pkg::CordicStepsDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_take,
  input  tcf_pkg::in_req_t  q_data,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_index,
  input  logic [16:0]       cfg_wr_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tcf_pkg::out_req_t out_data
);
  import tcf_pkg::*;

  localparam int StepW = $clog2(CordicStepsMax + 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_GYRO  = 8'b00000010,
    S_SETUP = 8'b00000100,
    S_ITER  = 8'b00001000,
    S_ROUND = 8'b00010000,
    S_MULA  = 8'b00100000,
    S_MULB  = 8'b01000000,
    S_BLEND = 8'b10000000
  } state_t;

  state_t state_r;
  in_req_t item_r;
  logic [16:0] weight_r;
  logic [15:0] period_r;
  logic signed [AngW-1:0] pitch_r, roll_r;
  logic axis_r;
  logic signed [CordW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;
  logic zero_r;
  logic [StepW-1:0] step_r;
  logic signed [AngW-1:0] acc_r;
  logic signed [39:0] p1_r, p2_r;
  logic outv_r;
  out_req_t out_r;

  logic signed [CordW-1:0] xs, ys;
  logic signed [15:0] num, den;
  logic signed [AngW-1:0] cur_ang;
  logic [16:0] a_sat;
  logic signed [31:0] gp, gr;
  logic signed [39:0] bsum;
  logic signed [AngW-1:0] bres;
  logic signed [ZW-1:0] zr;

  assign xs = x_r >>> step_r[4:0];
  assign ys = y_r >>> step_r[4:0];
  assign num = axis_r ? item_r.accel_x : item_r.accel_y;
  assign den = item_r.accel_z;
  assign cur_ang = axis_r ? roll_r : pitch_r;
  assign a_sat = weight_r[16] ? 17'd65536 : weight_r;
  assign gp = ($signed(item_r.pitch_rate) * $signed({1'b0, period_r}) + 32'sd32768) >>> 16;
  assign gr = ($signed(item_r.roll_rate) * $signed({1'b0, period_r}) + 32'sd32768) >>> 16;
  assign bsum = p1_r + p2_r + 40'sd32768;
  assign bres = sat20(bsum >>> 16);
  assign zr = (z_r + 26'sd256) >>> 9;

  assign q_take = (state_r == S_IDLE) && q_valid && !outv_r;
  assign out_valid = outv_r;
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (q_take) item_r <= q_data;
    case (state_r)
      S_SETUP: begin
        zero_r <= (num == 16'sd0) && (den == 16'sd0);
        step_r <= '0;
        if (den < 0) begin
          x_r <= -($signed({{(CordW-16){den[15]}}, den}) <<< 8);
          y_r <= -($signed({{(CordW-16){num[15]}}, num}) <<< 8);
          z_r <= (num >= 0) ? Deg180 : -Deg180;
        end else begin
          x_r <= $signed({{(CordW-16){den[15]}}, den}) <<< 8;
          y_r <= $signed({{(CordW-16){num[15]}}, num}) <<< 8;
          z_r <= '0;
        end
      end
      S_ITER: begin
        step_r <= step_r + 1'b1;
        if (y_r > 0) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + atan_entry(step_r[4:0]);
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - atan_entry(step_r[4:0]);
        end
      end
      S_ROUND: acc_r <= zero_r ? '0 : zr[AngW-1:0];
      S_MULA: p1_r <= 40'(cur_ang) * $signed({23'd0, 17'd65536 - a_sat});
      S_MULB: p2_r <= 40'(acc_r) * $signed({23'd0, a_sat});
      default: ;
    endcase
    if (!rst_n) begin
      state_r  <= S_IDLE;
      weight_r <= 17'd13107;
      period_r <= 16'd1311;
      pitch_r  <= '0;
      roll_r   <= '0;
      outv_r   <= 1'b0;
      axis_r   <= 1'b0;
    end else begin
      if (outv_r && !out_stall) outv_r <= 1'b0;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_BLEND_WEIGHT:  weight_r <= cfg_wr_data;
          CFG_SAMPLE_PERIOD: period_r <= cfg_wr_data[15:0];
          CFG_INITIAL_PITCH: pitch_r <= AngW'($signed(cfg_wr_data[15:0]));
          CFG_INITIAL_ROLL:  roll_r <= AngW'($signed(cfg_wr_data[15:0]));
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: if (q_take) state_r <= S_GYRO;
        S_GYRO: begin
          pitch_r <= sat20(40'(pitch_r) + 40'(gp));
          roll_r  <= sat20(40'(roll_r) + 40'(gr));
          axis_r  <= 1'b0;
          state_r <= S_SETUP;
        end
        S_SETUP: state_r <= S_ITER;
        S_ITER: if (step_r == StepW'(CORDIC_STEPS - 1)) state_r <= S_ROUND;
        S_ROUND: state_r <= S_MULA;
        S_MULA: state_r <= S_MULB;
        S_MULB: state_r <= S_BLEND;
        S_BLEND: begin
          if (axis_r) begin
            roll_r <= bres;
            out_r.pitch_estimate <= pitch_r;
            out_r.roll_estimate  <= bres;
            outv_r  <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            pitch_r <= bres;
            axis_r  <= 1'b1;
            state_r <= S_SETUP;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |=> state_r == S_GYRO) else $error("item taken outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (outv_r && out_stall) |=> outv_r) else $error("stalled result dropped");
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ITER |-> step_r < StepW'(CORDIC_STEPS)) else $error("step overrun");
`endif
endmodule

// ===== rtl/tilt_complementary_filter.sv =====
// Top level of the tilt complementary filter.
`timescale 1ns / 1ps
// One IMU sample in gives one pitch/roll result out. The front queue holds two
// requests; the engine handles one at a time, its pace set by the CORDIC unit
// that is shared by both angles, one micro-rotation per cycle. Once a request
// leaves the queue, the engine integrates the gyro rates, then runs the CORDIC
// and blend for pitch and then for roll before the result is registered. The
// engine takes no new request while a result waits. Configuration writes take
// effect at once.
module tilt_complementary_filter #(
  parameter int CORDIC_STEPS = tcf_pkg::CordicStepsDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tcf_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tcf_pkg::out_req_t out_data,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_index,
  input  logic [16:0]       cfg_wr_data
);
  import tcf_pkg::*;

  logic    q_valid, q_take;
  in_req_t q_data;

  tcf_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(in_valid), .wr_stall(in_stall), .wr_data(in_data),
    .rd_valid(q_valid), .rd_take(q_take), .rd_data(q_data)
  );

  tcf_engine #(.CORDIC_STEPS(CORDIC_STEPS)) u_engine (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_take(q_take), .q_data(q_data),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );
endmodule
